FILE: hdl/acia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package acia_pkg;

  // Frame register width (start, up to eight data, parity, stops)
  localparam int unsigned SHIFT_WIDTH = 11;

  // Item kinds
  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_RX_BIT = 2'd2,
    FUNC_TICK   = 2'd3
  } func_e;

  // Register select
  localparam logic SEL_CTRL = 1'b0;
  localparam logic SEL_DATA = 1'b1;

  // Counter divide select in control bits [1:0]
  typedef enum logic [1:0] {
    DIV_1        = 2'd0,
    DIV_16       = 2'd1,
    DIV_64       = 2'd2,
    DIV_MASTER_RESET = 2'd3
  } div_e;

  // Transmit control in control bits [6:5]
  typedef enum logic [1:0] {
    TC_RTS_LOW  = 2'd0,
    TC_TX_IRQ   = 2'd1,
    TC_RTS_HIGH = 2'd2,
    TC_BREAK    = 2'd3
  } tx_ctrl_e;

  // Status register bit positions
  localparam int unsigned ST_RX_FULL  = 0;
  localparam int unsigned ST_TX_EMPTY = 1;
  localparam int unsigned ST_OVERRUN  = 5;
  localparam int unsigned ST_IRQ      = 7;

  // Half-cycles per bit for each divider
  localparam logic [7:0] PERIOD_DIV_1  = 8'd2;
  localparam logic [7:0] PERIOD_DIV_16 = 8'd32;
  localparam logic [7:0] PERIOD_DIV_64 = 8'd128;

  // Frame lengths
  localparam logic [3:0] LEN_SHORT = 4'd10;
  localparam logic [3:0] LEN_LONG  = 4'd11;

  typedef struct packed {
    func_e      func;
    logic       reg_select;
    logic [7:0] write_data;
    logic       rx_bit;
    logic       tx_busy;
  } in_word_t;

  typedef struct packed {
    logic [7:0]             read_data;
    logic                   irq;
    logic                   rts_level;
    logic                   break_level;
    logic                   frame_valid;
    logic [SHIFT_WIDTH-1:0] frame_word;
    logic [3:0]             frame_length;
    logic [7:0]             bit_period;
  } out_word_t;

  // Bits per frame for a word format: start + data + parity + stops
  function automatic logic [3:0] frame_len(input logic [2:0] fmt);
    logic [3:0] len;
    unique case (fmt)
      3'd0, 3'd1, 3'd4, 3'd6, 3'd7: len = LEN_LONG;
      default:                      len = LEN_SHORT;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/acia_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input word channel
interface acia_in_if;
  logic               valid;
  logic               ready;
  acia_pkg::in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// Result word channel
interface acia_out_if;
  logic                valid;
  logic                ready;
  acia_pkg::out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/acia_tx_frame.sv
`timescale 1ns / 1ps
`default_nettype none

// Build the transmit frame (LSB first) for a data byte and word format
module acia_tx_frame (
  input  wire logic [7:0]                        data_i,
  input  wire logic [2:0]                        fmt_i,
  output      logic [acia_pkg::SHIFT_WIDTH-1:0]  word_o,
  output      logic [3:0]                        length_o
);
  import acia_pkg::*;

  logic [7:0] data_eff;
  logic       parity;

  // Drop bit 7 in seven-bit formats; even parity folds to ^data, odd inverts
  assign data_eff = fmt_i[2] ? data_i : {1'b0, data_i[6:0]};
  assign parity   = (^data_eff) ^ fmt_i[0];

  // Place data, parity and stop bits after the start bit
  always_comb begin
    unique case (fmt_i)
      3'd0, 3'd1: word_o = {1'b1, 1'b1, parity, data_eff[6:0], 1'b0};
      3'd2, 3'd3: word_o = {1'b0, 1'b1, parity, data_eff[6:0], 1'b0};
      3'd4:       word_o = {1'b1, 1'b1, data_eff, 1'b0};
      3'd5:       word_o = {1'b0, 1'b1, data_eff, 1'b0};
      default:    word_o = {1'b1, parity, data_eff, 1'b0};
    endcase
  end

  assign length_o = frame_len(fmt_i);

endmodule

`default_nettype wire

FILE: hdl/acia_serial_controller_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Word
// --------+-----+------------------------------------------------------------
// in_i    | in  | func, reg_select, write_data, rx_bit, tx_busy
// out_o   | out | read_data, irq, rts_level, break_level, frame_valid,
//         |     | frame_word, frame_length, bit_period
//
// One word per cycle unless out_o stalls: each accepted word updates the
// registers, and its result lands in the output register on the same edge.
// in_i.ready is high whenever the output register is empty or being drained,
// so a stalled consumer holds the result and blocks only further input.
// rst_ni clears all control and status; after reset the holding registers
// are empty and the format is 7E2, divide by one.
module acia_serial_controller_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  acia_in_if.sink   in_i,
  acia_out_if.source out_o
);
  import acia_pkg::*;

  // Device state
  logic [7:0] tx_data_q, tx_data_d;
  logic       tx_full_q, tx_full_d;
  logic [7:0] rx_data_q, rx_data_d;
  logic       rx_full_q, rx_full_d;
  logic       overrun_q, overrun_d;
  logic       irq_q, irq_d;
  logic [3:0] rx_count_q, rx_count_d;
  logic [SHIFT_WIDTH-1:0] rx_shift_q, rx_shift_d;
  div_e       div_q, div_d;
  logic [2:0] fmt_q, fmt_d;
  logic       tx_irq_en_q, tx_irq_en_d;
  logic       rx_irq_en_q, rx_irq_en_d;
  logic       rts_q, rts_d;
  logic       brk_q, brk_d;

  // Result register
  logic      out_valid_q;
  out_word_t out_word_q, out_word_d;

  logic       accept;
  in_word_t   in_w;
  logic [7:0] status;
  logic [7:0] tx_src;
  logic [SHIFT_WIDTH-1:0] frame_word;
  logic [3:0] frame_length;
  logic [3:0] rx_target;
  logic [3:0] rx_count_inc;
  logic [SHIFT_WIDTH-1:0] rx_shift_inc;
  logic       refresh;
  logic       tx_try;
  logic       tx_go;
  logic [7:0] rd;
  tx_ctrl_e   tc;
  logic [7:0] period;

  assign in_w       = in_i.payload;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Status byte from current state
  always_comb begin
    status               = '0;
    status[ST_RX_FULL]   = rx_full_q;
    status[ST_TX_EMPTY]  = !tx_full_q;
    status[ST_OVERRUN]   = overrun_q;
    status[ST_IRQ]       = irq_q;
  end

  // Frame source: a data write sends the new byte, a tick the held one
  assign tx_src = (in_w.func == FUNC_WRITE && in_w.reg_select == SEL_DATA)
                  ? in_w.write_data : tx_data_q;

  acia_tx_frame u_tx_frame (
    .data_i   (tx_src),
    .fmt_i    (fmt_q),
    .word_o   (frame_word),
    .length_o (frame_length)
  );

  // Receive shifter step
  assign rx_target    = frame_len(fmt_q);
  assign rx_count_inc = rx_count_q + 4'd1;
  assign rx_shift_inc = {in_w.rx_bit, rx_shift_q[SHIFT_WIDTH-1:1]};
  assign tc           = tx_ctrl_e'(in_w.write_data[6:5]);

  // Next state for one accepted word
  always_comb begin
    tx_data_d   = tx_data_q;
    tx_full_d   = tx_full_q;
    rx_data_d   = rx_data_q;
    rx_full_d   = rx_full_q;
    overrun_d   = overrun_q;
    rx_count_d  = rx_count_q;
    rx_shift_d  = rx_shift_q;
    div_d       = div_q;
    fmt_d       = fmt_q;
    tx_irq_en_d = tx_irq_en_q;
    rx_irq_en_d = rx_irq_en_q;
    rts_d       = rts_q;
    brk_d       = brk_q;
    refresh     = 1'b0;
    tx_try      = 1'b0;
    rd          = '0;
    if (accept) begin
      unique case (in_w.func)
        FUNC_READ: begin
          if (in_w.reg_select == SEL_DATA) begin
            overrun_d = 1'b0;
            rd        = rx_data_q;
            rx_full_d = 1'b0;
            refresh   = 1'b1;
          end else begin
            rd = status;
          end
        end
        FUNC_WRITE: begin
          if (in_w.reg_select == SEL_DATA) begin
            tx_data_d = in_w.write_data;
            tx_full_d = 1'b1;
            tx_try    = 1'b1;
            refresh   = 1'b1;
          end else if (div_e'(in_w.write_data[1:0]) == DIV_MASTER_RESET) begin
            tx_full_d   = 1'b0;
            rx_full_d   = 1'b0;
            rx_data_d   = '0;
            overrun_d   = 1'b0;
            rx_count_d  = '0;
            rx_shift_d  = '0;
            tx_irq_en_d = 1'b0;
            rx_irq_en_d = 1'b0;
            brk_d       = 1'b0;
            refresh     = 1'b1;
          end else begin
            div_d       = div_e'(in_w.write_data[1:0]);
            fmt_d       = in_w.write_data[4:2];
            rts_d       = (tc == TC_RTS_HIGH);
            tx_irq_en_d = (tc == TC_TX_IRQ);
            brk_d       = (tc == TC_BREAK);
            rx_irq_en_d = in_w.write_data[7];
            refresh     = 1'b1;
          end
        end
        FUNC_RX_BIT: begin
          rx_count_d = rx_count_inc;
          rx_shift_d = rx_shift_inc;
          if (rx_count_inc >= rx_target) begin
            rx_count_d = '0;
            if (rx_full_q) begin
              overrun_d = 1'b1;
            end
            // Drop the start bit and keep the next eight bits
            rx_data_d = (rx_target == LEN_LONG) ? rx_shift_inc[8:1] : rx_shift_inc[9:2];
            rx_full_d = 1'b1;
            refresh   = 1'b1;
          end
        end
        FUNC_TICK: begin
          tx_try  = 1'b1;
          refresh = 1'b1;
        end
        default: ;
      endcase
    end
    // Hand the held byte to the shifter when it is idle
    tx_go = tx_try && tx_full_d && !in_w.tx_busy;
    if (tx_go) begin
      tx_full_d = 1'b0;
    end
  end

  // Interrupt line follows the updated status on each refresh
  assign irq_d = refresh
                 ? ((rx_irq_en_d && (rx_full_d || overrun_d)) || (tx_irq_en_d && !tx_full_d))
                 : irq_q;

  // Bit period from the divider
  always_comb begin
    unique case (div_d)
      DIV_16:  period = PERIOD_DIV_16;
      DIV_64:  period = PERIOD_DIV_64;
      default: period = PERIOD_DIV_1;
    endcase
  end

  // Assemble the result word
  always_comb begin
    out_word_d.read_data    = rd;
    out_word_d.irq          = irq_d;
    out_word_d.rts_level    = rts_d;
    out_word_d.break_level  = brk_d;
    out_word_d.frame_valid  = tx_go;
    out_word_d.frame_word   = tx_go ? frame_word : '0;
    out_word_d.frame_length = tx_go ? frame_length : '0;
    out_word_d.bit_period   = period;
  end

  // Control and status registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_full_q   <= 1'b0;
      rx_data_q   <= '0;
      rx_full_q   <= 1'b0;
      overrun_q   <= 1'b0;
      irq_q       <= 1'b0;
      rx_count_q  <= '0;
      rx_shift_q  <= '0;
      div_q       <= DIV_1;
      fmt_q       <= '0;
      tx_irq_en_q <= 1'b0;
      rx_irq_en_q <= 1'b0;
      rts_q       <= 1'b0;
      brk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tx_full_q   <= tx_full_d;
      rx_data_q   <= rx_data_d;
      rx_full_q   <= rx_full_d;
      overrun_q   <= overrun_d;
      irq_q       <= irq_d;
      rx_count_q  <= rx_count_d;
      rx_shift_q  <= rx_shift_d;
      div_q       <= div_d;
      fmt_q       <= fmt_d;
      tx_irq_en_q <= tx_irq_en_d;
      rx_irq_en_q <= rx_irq_en_d;
      rts_q       <= rts_d;
      brk_q       <= brk_d;
      if (in_i.ready) begin
        out_valid_q <= accept;
      end
    end
  end

  // Payload registers: hold the byte and the result while stalled
  always_ff @(posedge clk_i) begin
    tx_data_q <= tx_data_d;
    if (accept) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_word_q;

endmodule

`default_nettype wire

FILE: hdl/acia_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks on the controller
module acia_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire acia_pkg::out_word_t out_word_i
);
  import acia_pkg::*;

  // Every accepted word produces a result on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> out_valid_i)
    else $error("accepted word produced no result");

  // Input side never stalls while the result register is empty
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  // Stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_word_i)))
    else $error("stalled result changed");

  // A frame carries a start bit and a legal length; without a frame both fields are zero
  a_frame_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_word_i.frame_valid
      ? (!out_word_i.frame_word[0] && (out_word_i.frame_length == LEN_SHORT ||
                                       out_word_i.frame_length == LEN_LONG))
      : (out_word_i.frame_word == '0 && out_word_i.frame_length == '0)))
    else $error("malformed frame fields");

  // Bit period is one of the divider settings
  a_period_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_word_i.bit_period == PERIOD_DIV_1 ||
                     out_word_i.bit_period == PERIOD_DIV_16 ||
                     out_word_i.bit_period == PERIOD_DIV_64))
    else $error("illegal bit period");

endmodule

bind acia_serial_controller_top acia_checker u_acia_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  (out_o.payload)
);

`default_nettype wire

FILE: sim/acia_tb_pkg.sv
`timescale 1ns / 1ps

package acia_tb_pkg;

  // Word formats in control bits [4:2]
  typedef enum logic [2:0] {
    FMT_7E2 = 3'd0,
    FMT_7O2 = 3'd1,
    FMT_7E1 = 3'd2,
    FMT_7O1 = 3'd3,
    FMT_8N2 = 3'd4,
    FMT_8N1 = 3'd5,
    FMT_8E1 = 3'd6,
    FMT_8O1 = 3'd7
  } fmt_e;

  function automatic bit eight_data(input fmt_e f);
    return f inside {FMT_8N2, FMT_8N1, FMT_8E1, FMT_8O1};
  endfunction

  function automatic bit with_parity(input fmt_e f);
    return !(f inside {FMT_8N2, FMT_8N1});
  endfunction

  function automatic bit odd_parity(input fmt_e f);
    return f inside {FMT_7O2, FMT_7O1, FMT_8O1};
  endfunction

  function automatic int unsigned stop_count(input fmt_e f);
    return (f inside {FMT_7E2, FMT_7O2, FMT_8N2}) ? 2 : 1;
  endfunction

  // Start bit, data, optional parity and stops
  function automatic int unsigned line_bits(input fmt_e f);
    return 1 + (eight_data(f) ? 8 : 7) + (with_parity(f) ? 1 : 0) + stop_count(f);
  endfunction

endpackage

FILE: sim/acia_reply_checker.sv
`timescale 1ns / 1ps

module acia_reply_checker
  import acia_pkg::*;
  import acia_tb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_i,
  input  in_word_t        in_word_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  out_word_t       out_word_i,
  output int unsigned     mismatch_count_o,
  output int unsigned     pending_o
);

  // Shadow copy of the controller registers
  logic [7:0]             tx_byte, rx_byte;
  logic                   tx_empty, rx_empty, overrun, irq_q;
  logic [3:0]             rx_count;
  logic [SHIFT_WIDTH-1:0] rx_shreg;
  div_e                   div_sel;
  fmt_e                   fmt;
  logic                   tx_ie, rx_ie, rts, brk;

  out_word_t              reply_queue[$];
  out_word_t              want;
  int unsigned            mismatches;

  assign mismatch_count_o = mismatches;

  // Clear what a master reset clears
  function automatic void clear_line_state();
    tx_byte  = '0;
    rx_byte  = '0;
    tx_empty = 1'b1;
    rx_empty = 1'b1;
    overrun  = 1'b0;
    rx_count = '0;
    rx_shreg = '0;
    tx_ie    = 1'b0;
    rx_ie    = 1'b0;
    brk      = 1'b0;
    irq_q    = 1'b0;
  endfunction

  function automatic logic [7:0] status_byte();
    logic [7:0] s;
    s = '0;
    s[ST_RX_FULL]  = !rx_empty;
    s[ST_TX_EMPTY] = tx_empty;
    s[ST_OVERRUN]  = overrun;
    s[ST_IRQ]      = irq_q;
    return s;
  endfunction

  // Hand the holding byte to the shifter when it is free
  function automatic void hand_off_frame(input logic busy, inout out_word_t r);
    logic [7:0]             d;
    logic [SHIFT_WIDTH-1:0] fw;
    int unsigned            pos;
    if (tx_empty || busy) return;
    d = tx_byte;
    if (!eight_data(fmt)) d[7] = 1'b0;
    fw  = {2'b00, d, 1'b0};
    pos = eight_data(fmt) ? 9 : 8;
    if (with_parity(fmt)) begin
      fw[pos] = (^d) ^ odd_parity(fmt);
      pos++;
    end
    repeat (stop_count(fmt)) begin
      fw[pos] = 1'b1;
      pos++;
    end
    r.frame_valid  = 1'b1;
    r.frame_word   = fw;
    r.frame_length = 4'(line_bits(fmt));
    tx_empty       = 1'b1;
  endfunction

  // Advance the shadow registers by one word and build its reply
  function automatic out_word_t apply_word(input in_word_t w);
    out_word_t   r;
    tx_ctrl_e    tc;
    int unsigned target;
    r = '0;
    case (w.func)
      FUNC_READ: begin
        if (w.reg_select == SEL_DATA) begin
          overrun     = 1'b0;
          r.read_data = rx_byte;
          rx_empty    = 1'b1;
        end else begin
          r.read_data = status_byte();
        end
      end
      FUNC_WRITE: begin
        if (w.reg_select == SEL_DATA) begin
          tx_byte  = w.write_data;
          tx_empty = 1'b0;
          hand_off_frame(w.tx_busy, r);
        end else if (div_e'(w.write_data[1:0]) == DIV_MASTER_RESET) begin
          clear_line_state();
        end else begin
          tc      = tx_ctrl_e'(w.write_data[6:5]);
          div_sel = div_e'(w.write_data[1:0]);
          fmt     = fmt_e'(w.write_data[4:2]);
          rts     = (tc == TC_RTS_HIGH);
          tx_ie   = (tc == TC_TX_IRQ);
          brk     = (tc == TC_BREAK);
          rx_ie   = w.write_data[7];
        end
      end
      FUNC_RX_BIT: begin
        target   = line_bits(fmt);
        rx_count = rx_count + 4'd1;
        rx_shreg = {w.rx_bit, rx_shreg[SHIFT_WIDTH-1:1]};
        if (rx_count >= target) begin
          rx_count = '0;
          if (!rx_empty) overrun = 1'b1;
          rx_byte  = 8'(rx_shreg >> (SHIFT_WIDTH + 1 - target));
          rx_empty = 1'b0;
        end
      end
      default: hand_off_frame(w.tx_busy, r);
    endcase
    // Interrupt follows receive full or overrun, and transmit empty
    irq_q = (rx_ie && (!rx_empty || overrun)) || (tx_ie && tx_empty);
    r.irq         = irq_q;
    r.rts_level   = rts;
    r.break_level = brk;
    case (div_sel)
      DIV_16:  r.bit_period = PERIOD_DIV_16;
      DIV_64:  r.bit_period = PERIOD_DIV_64;
      default: r.bit_period = PERIOD_DIV_1;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      if (mismatches <= 100)
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
    end
  endfunction

  // Compare each result word with the oldest prediction, then predict the new one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_sel = DIV_1;
      fmt     = FMT_7E2;
      rts     = 1'b0;
      clear_line_state();
      reply_queue.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (reply_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 100) $error("result word with no prediction waiting");
        end else begin
          want = reply_queue.pop_front();
          check_field("read_data", want.read_data, out_word_i.read_data);
          check_field("irq", want.irq, out_word_i.irq);
          check_field("rts_level", want.rts_level, out_word_i.rts_level);
          check_field("break_level", want.break_level, out_word_i.break_level);
          check_field("frame_valid", want.frame_valid, out_word_i.frame_valid);
          check_field("frame_word", want.frame_word, out_word_i.frame_word);
          check_field("frame_length", want.frame_length, out_word_i.frame_length);
          check_field("bit_period", want.bit_period, out_word_i.bit_period);
        end
      end
      if (in_valid_i && in_ready_i) reply_queue.push_back(apply_word(in_word_i));
    end
    pending_o = reply_queue.size();
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import acia_pkg::*;
  import acia_tb_pkg::*;

  localparam int unsigned TOTAL_WORDS     = 1900;
  localparam int unsigned PRESSURE_AT     = 700;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT     = 3000;
  localparam int unsigned DRAIN_CYCLES    = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned mismatches, pending;
  int unsigned words_sent, quiet_cycles;
  bit          burst_mode, hold_off_req, pressure_done;
  fmt_e        line_fmt;

  acia_in_if  in_ch ();
  acia_out_if out_ch ();

  acia_serial_controller_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  acia_reply_checker reply_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_ch.valid),
    .in_ready_i       (in_ch.ready),
    .in_word_i        (in_ch.payload),
    .out_valid_i      (out_ch.valid),
    .out_ready_i      (out_ch.ready),
    .out_word_i       (out_ch.payload),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] ctrl_word(input logic rx_irq, input tx_ctrl_e tc,
                                           input fmt_e f, input div_e d);
    return {rx_irq, tc, f, d};
  endfunction

  // Offer one word and hold it until the block takes it
  task automatic offer(input func_e f, input logic sel, input logic [7:0] wd,
                       input logic bitv, input logic busy);
    in_word_t    w;
    int unsigned gap;
    w.func       = f;
    w.reg_select = sel;
    w.write_data = wd;
    w.rx_bit     = bitv;
    w.tx_busy    = busy;
    gap = burst_mode ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    words_sent++;
    // Track the format so that line frames stay aligned
    if (f == FUNC_WRITE && sel == SEL_CTRL && div_e'(wd[1:0]) != DIV_MASTER_RESET)
      line_fmt = fmt_e'(wd[4:2]);
  endtask

  // Shift a frame in on the receive line, LSB first
  task automatic shift_in_frame(input int unsigned nbits,
                                input logic [SHIFT_WIDTH-1:0] pattern);
    for (int i = 0; i < nbits; i++)
      offer(FUNC_RX_BIT, 1'($urandom), 8'($urandom), pattern[i], 1'($urandom));
  endtask

  // Result consumer: random stalls, plus one long hold-off on request
  initial begin
    int unsigned n;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        n = burst_mode ? 0 : pick_gap();
        if (n != 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("acia_serial_controller_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned      pick;
    logic [7:0]       wd;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    rst_ni        = 1'b0;
    line_fmt      = FMT_7E2;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset state, transmit holding, a received frame, break, master reset
    offer(FUNC_READ, SEL_CTRL, 8'h00, 1'b0, 1'b0);
    offer(FUNC_READ, SEL_DATA, 8'h00, 1'b0, 1'b0);
    offer(FUNC_WRITE, SEL_CTRL, ctrl_word(1'b1, TC_TX_IRQ, FMT_7E2, DIV_16), 1'b0, 1'b0);
    offer(FUNC_WRITE, SEL_DATA, 8'h55, 1'b0, 1'b0);
    offer(FUNC_WRITE, SEL_DATA, 8'hFF, 1'b1, 1'b1);
    offer(FUNC_TICK, SEL_DATA, 8'hFF, 1'b1, 1'b1);
    offer(FUNC_TICK, SEL_DATA, 8'hFF, 1'b1, 1'b0);
    offer(FUNC_WRITE, SEL_CTRL, ctrl_word(1'b1, TC_RTS_HIGH, FMT_8N1, DIV_64), 1'b0, 1'b0);
    shift_in_frame(line_bits(FMT_8N1), {2'b01, 8'hA5, 1'b0});
    offer(FUNC_READ, SEL_CTRL, 8'hFF, 1'b1, 1'b1);
    offer(FUNC_READ, SEL_DATA, 8'h00, 1'b0, 1'b0);
    offer(FUNC_WRITE, SEL_CTRL, ctrl_word(1'b0, TC_BREAK, FMT_8E1, DIV_1), 1'b0, 1'b0);
    offer(FUNC_WRITE, SEL_CTRL, ctrl_word(1'b1, TC_BREAK, FMT_8O1, DIV_MASTER_RESET),
          1'b0, 1'b0);
    offer(FUNC_WRITE, SEL_DATA, 8'h7F, 1'b0, 1'b0);
    offer(FUNC_RX_BIT, SEL_DATA, 8'hFF, 1'b1, 1'b1);

    // Random: mostly well-formed frames and transfers, some noise
    while (words_sent < TOTAL_WORDS) begin
      if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
      if (!pressure_done && words_sent >= PRESSURE_AT) begin
        hold_off_req  = 1'b1;
        burst_mode    = 1'b1;
        pressure_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        wd = 8'($urandom);
        // Keep master resets rare
        if (div_e'(wd[1:0]) == DIV_MASTER_RESET && $urandom_range(0, 4) != 0)
          wd[1:0] = 2'($urandom_range(0, 2));
        offer(FUNC_WRITE, SEL_CTRL, wd, 1'($urandom), 1'($urandom));
      end else if (pick < 42) begin
        shift_in_frame(line_bits(line_fmt), 11'($urandom));
        if ($urandom_range(0, 2) == 0)
          offer(FUNC_READ, 1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end else if (pick < 67) begin
        offer(FUNC_WRITE, SEL_DATA, 8'($urandom), 1'($urandom), 1'($urandom));
        repeat ($urandom_range(0, 3))
          offer(FUNC_TICK, 1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end else if (pick < 85) begin
        offer(FUNC_READ, 1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        offer(func_e'(2'($urandom)), 1'($urandom), 8'($urandom), 1'($urandom),
              1'($urandom));
      end
    end

    // Drain: wait for every predicted result, then a short tail
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("acia_serial_controller_top regression: pass");
    end else begin
      $display("acia_serial_controller_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/acia_pkg.sv
hdl/acia_if.sv
hdl/acia_tx_frame.sv
hdl/acia_serial_controller_top.sv
hdl/acia_checker.sv
sim/acia_tb_pkg.sv
sim/acia_reply_checker.sv
sim/testbench.sv
